>>> rtl/sfha_pkg.sv
// ----------------------------------------------------------------------------
// sfha_pkg: shared constants for the segregated-fit heap allocator
// Sizes of the heap, the class table and the op and status codes.
// ----------------------------------------------------------------------------
package sfha_pkg;
  localparam int HeapBytes  = 65536;
  localparam int NumClasses = 20;
  localparam int ChunkBytes = 4096;
  localparam int HeapWords  = HeapBytes / 4;
  localparam int WordAw     = $clog2(HeapWords);
  localparam int ClassW     = $clog2(NumClasses);
  localparam int WalkLimit  = HeapBytes / 16 + 2;
  localparam int WalkW      = $clog2(WalkLimit + 1);

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOMEM = 2'd2
  } status_e;
endpackage

>>> rtl/sfha_ram.sv
// ----------------------------------------------------------------------------
// sfha_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module sfha_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

>>> rtl/segregated_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// segregated_fit_heap_allocator_top
// Boundary-tag heap allocator with size-class free lists in one word RAM.
// ----------------------------------------------------------------------------
//  channel  signals                           direction
//  req      req_valid_i/ready_o, op, bytes,   in
//           block_addr
//  rsp      rsp_valid_o/ready_i, result_addr, out
//           status
// One request at a time. The response goes valid straight from dispatch for a
// zero-size allocate, an allocate before init or an unused op; list walks set
// the rest, and each walk is bounded by WalkLimit nodes. Each heap word read
// passes through RD and RDW on the single RAM port, each write through WR.
// Reset clears control state, class heads and heap_top; heap RAM is
// undefined until init writes it. A stalled response holds the block; a new
// request is taken once the response is gone.
// ----------------------------------------------------------------------------
module segregated_fit_heap_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] req_bytes_i,
  input  logic [15:0] block_addr_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic [15:0] result_addr_o,
  output logic [1:0]  status_o
);
  import sfha_pkg::*;

  // micro-ops
  localparam logic [5:0] S_IDLE = 6'd0,  S_RD = 6'd1,  S_RDW = 6'd2,  S_RSP = 6'd3,
                         S_WR = 6'd4,    S_DISP = 6'd5,
                         S_I1 = 6'd6,    S_GROW = 6'd7,  S_G1 = 6'd8,   S_G2 = 6'd9,
                         S_M0 = 6'd10,   S_M1 = 6'd11,   S_M2 = 6'd12,  S_M3 = 6'd13,
                         S_M4 = 6'd14,   S_M5 = 6'd15,   S_M6 = 6'd16,  S_M7 = 6'd17,
                         S_M8 = 6'd18,
                         S_RM0 = 6'd19,  S_RM1 = 6'd20,  S_RM2 = 6'd21, S_RM3 = 6'd22,
                         S_IN0 = 6'd23,  S_IN1 = 6'd24,  S_IN2 = 6'd25, S_IN3 = 6'd26,
                         S_IN4 = 6'd27,  S_IN5 = 6'd28,
                         S_F0 = 6'd29,   S_F1 = 6'd30,   S_F2 = 6'd31,  S_F3 = 6'd32,
                         S_F4 = 6'd33,   S_F5 = 6'd34,
                         S_P0 = 6'd35,   S_P1 = 6'd36,   S_P2 = 6'd37,  S_P3 = 6'd38,
                         S_P4 = 6'd39,   S_P5 = 6'd40,
                         S_X0 = 6'd41,   S_X1 = 6'd42,   S_X2 = 6'd43,  S_X3 = 6'd44,
                         S_A0 = 6'd45,   S_A1 = 6'd46,   S_A2 = 6'd47,  S_A3 = 6'd48;

  // callers of the shared subroutines
  localparam logic [1:0] RET_GROW = 2'd0, RET_MERGE = 2'd1;
  localparam logic [1:0] RM_NEXT = 2'd0, RM_PREV = 2'd1, RM_PLACE = 2'd2;

  logic [5:0]  state_q, state_d, ret_q, ret_d;   // ret_q: state after RAM access
  logic [1:0]  op_q, op_d;
  logic [15:0] req_q, req_d, addr_q, addr_d;
  logic [15:0] res_q, res_d;
  logic [1:0]  stat_q, stat_d;
  logic [15:0] head_q [NumClasses];
  logic        head_we;
  logic [ClassW-1:0] head_idx;
  logic [15:0] head_wv;
  logic [16:0] top_q, top_d;

  // RAM access registers
  logic [31:0] ra_q, ra_d;          // byte address
  logic [31:0] wv_q, wv_d;
  logic [31:0] rv_q, rv_d;          // last read word

  // working registers
  logic [31:0] bp_q, bp_d, size_q, size_d, nb_q, nb_d, pf_q, pf_d;
  logic        pfree_q, pfree_d;
  logic [31:0] p_q, p_d, s_q, s_d, cur_q, cur_d, prv_q, prv_d, rb_q, rb_d;
  logic [ClassW-1:0] c_q, c_d;
  logic [31:0] srch_q, srch_d, asize_q, asize_d, csize_q, csize_d;
  logic [WalkW-1:0] n_q, n_d;
  logic [1:0]  mret_q, mret_d;      // return from merge
  logic [1:0]  rmret_q, rmret_d;    // return from remove
  logic        inret_q, inret_d;    // return from insert: 0 merge, 1 place
  logic [1:0]  xstep_q, xstep_d;

  logic        ram_we;
  logic [WordAw-1:0] ram_a;
  logic [31:0] ram_rd;
  logic        inrange;

  assign inrange = (ra_q[31:2] < 30'(HeapWords));
  assign ram_a   = ra_q[WordAw+1:2];

  sfha_ram #(.Width(32), .Depth(HeapWords)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_a),
    .wdata_i(wv_q),
    .rdata_o(ram_rd)
  );

  function automatic logic [ClassW-1:0] class_of(input logic [31:0] sz);
    logic [ClassW-1:0] c;
    c = '0;
    for (int i = 1; i < 32; i++)
      if (sz[i]) c = (i >= NumClasses - 1) ? ClassW'(NumClasses - 1) : ClassW'(i);
    return c;
  endfunction

  assign req_ready_o   = (state_q == S_IDLE);
  assign rsp_valid_o   = (state_q == S_RSP);
  assign result_addr_o = res_q;
  assign status_o      = stat_q;

  always_comb begin
    logic [31:0] t;
    state_d = state_q; ret_d = ret_q; op_d = op_q; req_d = req_q; addr_d = addr_q;
    res_d = res_q; stat_d = stat_q; top_d = top_q;
    ra_d = ra_q; wv_d = wv_q; rv_d = rv_q;
    bp_d = bp_q; size_d = size_q; nb_d = nb_q; pf_d = pf_q;
    pfree_d = pfree_q; p_d = p_q; s_d = s_q;
    cur_d = cur_q; prv_d = prv_q; rb_d = rb_q; c_d = c_q; srch_d = srch_q;
    asize_d = asize_q; csize_d = csize_q; n_d = n_q;
    mret_d = mret_q; rmret_d = rmret_q; inret_d = inret_q; xstep_d = xstep_q;
    head_we = 1'b0; head_idx = c_q; head_wv = '0;
    ram_we = 1'b0;
    t = '0;

    unique case (state_q)
      S_IDLE: if (req_valid_i) begin
        op_d = op_i; req_d = req_bytes_i; addr_d = block_addr_i;
        res_d = '0; stat_d = ST_OK; state_d = S_DISP;
      end
      S_RSP: if (rsp_ready_i) state_d = S_IDLE;
      // read: ra_q set, go to RDW, then ret_q with rv_q
      S_RD:  state_d = S_RDW;
      S_RDW: begin
        rv_d = inrange ? ram_rd : 32'd0;
        state_d = ret_q;
      end
      S_WR: begin
        ram_we = inrange;
        state_d = ret_q;
      end
      S_DISP: begin
        unique case (op_q)
          OP_INIT: begin
            xstep_d = 2'd0; ra_d = 32'd0; wv_d = 32'd0; ret_d = S_I1; state_d = S_WR;
          end
          OP_ALLOC: begin
            if (req_q == 16'd0) begin
              stat_d = ST_ZERO; state_d = S_RSP;
            end else if (top_q == 17'd0) begin
              stat_d = ST_NOMEM; state_d = S_RSP;
            end else begin
              asize_d = (32'(req_q) + 32'd15) & ~32'd7;
              srch_d  = (32'(req_q) + 32'd15) & ~32'd7;
              c_d = '0; state_d = S_F0;
            end
          end
          OP_FREE: begin
            ra_d = 32'(addr_q) - 32'd4; ret_d = S_A0; state_d = S_RD;
          end
          default: state_d = S_RSP;
        endcase
      end
      // init: words 0..3 then grow(chunk)
      S_I1: begin
        xstep_d = xstep_q + 2'd1;
        unique case (xstep_q)
          2'd0: begin ra_d = 32'd4;  wv_d = 32'd9; ret_d = S_I1; state_d = S_WR; end
          2'd1: begin ra_d = 32'd8;  wv_d = 32'd9; ret_d = S_I1; state_d = S_WR; end
          2'd2: begin ra_d = 32'd12; wv_d = 32'd1; ret_d = S_I1; state_d = S_WR; end
          default: begin
            top_d = 17'd16; size_d = 32'(ChunkBytes); state_d = S_GROW;
          end
        endcase
      end
      // grow by size_q (already 8-aligned)
      S_GROW: begin
        if (32'(top_q) > 32'(HeapBytes) || size_q > 32'(HeapBytes) - 32'(top_q)) begin
          stat_d = ST_NOMEM; state_d = S_RSP;
        end else begin
          bp_d = 32'(top_q);
          ra_d = 32'(top_q) - 32'd4; wv_d = size_q; ret_d = S_G1; state_d = S_WR;
        end
      end
      S_G1: begin
        ra_d = bp_q + size_q - 32'd8; wv_d = size_q; ret_d = S_G2; state_d = S_WR;
      end
      S_G2: begin
        ra_d = bp_q + size_q - 32'd4; wv_d = 32'd1;
        top_d = 17'(32'(top_q) + size_q);
        mret_d = RET_GROW; ret_d = S_M0; state_d = S_WR;
      end
      // merge(bp_q): size_q = tag size of bp
      S_M0: begin ra_d = bp_q - 32'd8; ret_d = S_M1; state_d = S_RD; end
      S_M1: begin
        pf_d = rv_q; pfree_d = !rv_q[0]; nb_d = bp_q + size_q;
        ra_d = bp_q + size_q - 32'd4; ret_d = S_M2; state_d = S_RD;
      end
      S_M2: begin
        if (!rv_q[0]) begin
          rb_d = nb_q; t = rv_q & ~32'd7; csize_d = t;
          rmret_d = RM_NEXT; state_d = S_RM0;
        end else state_d = S_M3;
      end
      S_M3: begin
        if (pfree_q) begin
          rb_d = bp_q - (pf_q & ~32'd7);
          ra_d = bp_q - (pf_q & ~32'd7) - 32'd4; ret_d = S_M4; state_d = S_RD;
        end else state_d = S_M5;
      end
      S_M4: begin
        csize_d = rv_q & ~32'd7; rmret_d = RM_PREV; state_d = S_RM0;
      end
      S_M5: begin ra_d = bp_q - 32'd4; wv_d = size_q; ret_d = S_M6; state_d = S_WR; end
      S_M6: begin
        ra_d = bp_q + size_q - 32'd8; wv_d = size_q; ret_d = S_M7; state_d = S_WR;
      end
      S_M7: begin
        rb_d = bp_q; csize_d = size_q; inret_d = 1'b0; state_d = S_IN0;
      end
      S_M8: begin
        unique case (mret_q)
          RET_GROW: begin
            if (op_q == OP_INIT) state_d = S_RSP;
            else begin asize_d = asize_q; state_d = S_P0; end
          end
          default: state_d = S_RSP;
        endcase
      end
      // list_remove(rb_q), csize_q = its size
      S_RM0: begin ra_d = rb_q; ret_d = S_RM1; state_d = S_RD; end
      S_RM1: begin p_d = rv_q; ra_d = rb_q + 32'd4; ret_d = S_RM2; state_d = S_RD; end
      S_RM2: begin
        s_d = rv_q;
        if (rv_q != 0) begin
          ra_d = rv_q; wv_d = p_q; ret_d = S_RM3; state_d = S_WR;
        end else state_d = S_RM3;
      end
      S_RM3: begin
        if (p_q != 0 && xstep_q != 2'd3) begin
          ra_d = p_q + 32'd4; wv_d = s_q; xstep_d = 2'd3; ret_d = S_RM3; state_d = S_WR;
        end else begin
          if (p_q == 0) begin
            head_we = 1'b1; head_idx = class_of(csize_q); head_wv = s_q[15:0];
          end
          xstep_d = 2'd0;
          unique case (rmret_q)
            RM_NEXT: begin size_d = size_q + csize_q; state_d = S_M3; end
            RM_PREV: begin size_d = size_q + csize_q; bp_d = rb_q; state_d = S_M5; end
            default: state_d = S_P1;
          endcase
        end
      end
      // list_insert(rb_q, csize_q)
      S_IN0: begin
        c_d = class_of(csize_q); prv_d = '0;
        cur_d = 32'(head_q[class_of(csize_q)]); n_d = '0; state_d = S_IN1;
      end
      S_IN1: begin
        if (cur_q != 0 && n_q < WalkW'(WalkLimit)) begin
          ra_d = cur_q - 32'd4; ret_d = S_IN2; state_d = S_RD;
        end else state_d = S_IN3;
      end
      S_IN2: begin
        if (csize_q > (rv_q & ~32'd7)) begin
          prv_d = cur_q; ra_d = cur_q + 32'd4; n_d = n_q + 1'b1;
          ret_d = S_IN5; state_d = S_RD;
        end else state_d = S_IN3;
      end
      S_IN5: begin cur_d = rv_q; state_d = S_IN1; end
      S_IN3: begin
        ra_d = rb_q; wv_d = prv_q; xstep_d = 2'd0; ret_d = S_IN4; state_d = S_WR;
      end
      S_IN4: begin
        xstep_d = xstep_q + 2'd1;
        unique case (xstep_q)
          2'd0: begin ra_d = rb_q + 32'd4; wv_d = cur_q; ret_d = S_IN4; state_d = S_WR; end
          2'd1: begin
            if (cur_q != 0) begin
              ra_d = cur_q; wv_d = rb_q; ret_d = S_IN4; state_d = S_WR;
            end
          end
          2'd2: begin
            if (prv_q != 0) begin
              ra_d = prv_q + 32'd4; wv_d = rb_q; ret_d = S_IN4; state_d = S_WR;
            end else begin
              head_we = 1'b1; head_idx = c_q; head_wv = rb_q[15:0];
            end
          end
          default: begin
            xstep_d = 2'd0;
            state_d = inret_q ? S_RSP : S_M8;
          end
        endcase
      end
      // find_fit over classes
      S_F0: begin
        if ((32'(c_q) == NumClasses - 1) || (srch_q <= 32'd1 && head_q[c_q] != 0)) begin
          cur_d = 32'(head_q[c_q]); n_d = '0; state_d = S_F1;
        end else state_d = S_F4;
      end
      S_F1: begin
        if (cur_q != 0 && n_q < WalkW'(WalkLimit)) begin
          ra_d = cur_q - 32'd4; ret_d = S_F2; state_d = S_RD;
        end else state_d = S_F3;
      end
      S_F2: begin
        if (asize_q > (rv_q & ~32'd7)) begin
          ra_d = cur_q + 32'd4; n_d = n_q + 1'b1; ret_d = S_F5; state_d = S_RD;
        end else begin
          bp_d = cur_q; state_d = S_P0;   // fit found
        end
      end
      S_F5: begin cur_d = rv_q; state_d = S_F1; end
      S_F3: begin
        // walk ended without fit (cur 0 or limit); limit case needs recheck
        if (cur_q != 0) begin
          ra_d = cur_q - 32'd4; ret_d = S_X0; state_d = S_RD;
        end else state_d = S_F4;
      end
      S_X0: begin
        if (asize_q <= (rv_q & ~32'd7)) begin bp_d = cur_q; state_d = S_P0; end
        else state_d = S_F4;
      end
      S_F4: begin
        srch_d = srch_q >> 1;
        if (32'(c_q) == NumClasses - 1) begin
          size_d = (asize_q > 32'(ChunkBytes)) ? asize_q : 32'(ChunkBytes);
          state_d = S_GROW;
        end else begin
          c_d = c_q + 1'b1; state_d = S_F0;
        end
      end
      // place(bp_q, asize_q)
      S_P0: begin ra_d = bp_q - 32'd4; ret_d = S_P5; state_d = S_RD; end
      S_P5: begin
        csize_d = rv_q & ~32'd7; size_d = rv_q & ~32'd7; rb_d = bp_q;
        rmret_d = RM_PLACE; state_d = S_RM0;
      end
      S_P1: begin
        res_d = bp_q[15:0];
        if (size_q - asize_q >= 32'd16) begin
          ra_d = bp_q - 32'd4; wv_d = asize_q | 32'd1; ret_d = S_P2; state_d = S_WR;
        end else begin
          ra_d = bp_q - 32'd4; wv_d = size_q | 32'd1; ret_d = S_P4; state_d = S_WR;
        end
      end
      S_P2: begin
        ra_d = bp_q + asize_q - 32'd8; wv_d = asize_q | 32'd1; ret_d = S_P3; state_d = S_WR;
      end
      S_P3: begin
        if (xstep_q == 2'd0) begin
          ra_d = bp_q + asize_q - 32'd4; wv_d = size_q - asize_q;
          xstep_d = 2'd1; ret_d = S_P3; state_d = S_WR;
        end else begin
          ra_d = bp_q + size_q - 32'd8; wv_d = size_q - asize_q;
          xstep_d = 2'd0; ret_d = S_X1; state_d = S_WR;
        end
      end
      S_X1: begin
        rb_d = bp_q + asize_q; csize_d = size_q - asize_q; inret_d = 1'b1; state_d = S_IN0;
      end
      S_P4: begin
        ra_d = bp_q + size_q - 32'd8; wv_d = size_q | 32'd1; ret_d = S_RSP; state_d = S_WR;
      end
      // free checks: header in rv_q
      S_A0: begin
        pf_d = rv_q; size_d = rv_q & ~32'd7;
        t = rv_q & ~32'd7;
        if (addr_q[2:0] == 3'd0 && addr_q >= 16'd16 && 17'(addr_q) < top_q && rv_q[0] &&
            t >= 32'd16 && t <= 32'(top_q) - 32'(addr_q)) begin
          ra_d = 32'(addr_q) + t - 32'd8; ret_d = S_A1; state_d = S_RD;
        end else state_d = S_RSP;
      end
      S_A1: begin
        if (rv_q == pf_q) begin
          bp_d = 32'(addr_q);
          ra_d = 32'(addr_q) - 32'd4; wv_d = size_q; ret_d = S_A2; state_d = S_WR;
        end else state_d = S_RSP;
      end
      S_A2: begin
        ra_d = bp_q + size_q - 32'd8; wv_d = size_q; ret_d = S_A3; state_d = S_WR;
      end
      S_A3: begin mret_d = RET_MERGE; state_d = S_M0; end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      top_q   <= '0;
      xstep_q <= '0;
      for (int i = 0; i < NumClasses; i++) head_q[i] <= '0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      xstep_q <= xstep_d;
      if (state_q == S_DISP && op_q == OP_INIT)
        for (int i = 0; i < NumClasses; i++) head_q[i] <= '0;
      else if (head_we) head_q[head_idx] <= head_wv;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; op_q <= op_d; req_q <= req_d; addr_q <= addr_d;
    res_q <= res_d; stat_q <= stat_d;
    ra_q <= ra_d; wv_q <= wv_d; rv_q <= rv_d;
    bp_q <= bp_d; size_q <= size_d; nb_q <= nb_d; pf_q <= pf_d;
    pfree_q <= pfree_d; p_q <= p_d; s_q <= s_d;
    cur_q <= cur_d; prv_q <= prv_d; rb_q <= rb_d; c_q <= c_d; srch_q <= srch_d;
    asize_q <= asize_d; csize_q <= csize_d; n_q <= n_d;
    mret_q <= mret_d; rmret_q <= rmret_d; inret_q <= inret_d;
  end
endmodule
